// ----- src/uglr_pkg.sv -----
// ----------------------------------------------------------------------------
// uglr_pkg: shared types and constants of the uniform grid linear resampler
// Sequencer states, status codes and stream widths.
// ----------------------------------------------------------------------------
package uglr_pkg;

  localparam int unsigned MaxRunDefault = 64;

  localparam int unsigned XW       = 32;
  localparam int unsigned YW       = 32;
  localparam int unsigned GXW      = 33;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned OutUserW = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NOT_INCR = 2'd1,
    STS_RUN_GAP  = 2'd2,
    STS_SHORT    = 2'd3
  } status_e;

endpackage

// ----- src/uniform_grid_linear_resampler.sv -----
// ----------------------------------------------------------------------------
// uniform_grid_linear_resampler: resample a point series onto a uniform grid
//
// Channel   Dir  Signals                       Payload
// s_axis    in   tvalid tready tdata tlast     point_x, point_y / last_point
// m_axis    out  tvalid tready tdata tlast     grid_x, grid_y / run_last
//                tuser                         series_done, status
// cfg       in   cfg_valid_i cfg_ready_o       grid_step
//                cfg_data_i
//
// A point is taken while idle, then a grid walk finds the samples in reach,
// with count <= min(MAX_RUN, 64) + 1. Each interpolated sample takes a
// multiply step, the restoring divider, a format step and an output step;
// no new point is taken until the previous one is done.
// Reset clears the series state and sets grid_step to 1. While m_axis_tready
// is low the pending result holds and the sequencer waits.
// ----------------------------------------------------------------------------
module uniform_grid_linear_resampler #(
  parameter int unsigned MAX_RUN = uglr_pkg::MaxRunDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [31:0]                   cfg_data_i,
  // input points
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [uglr_pkg::InDataW-1:0]  s_axis_tdata,   // point_x, point_y
  input  logic                          s_axis_tlast,   // last_point
  // output samples
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [uglr_pkg::OutDataW-1:0] m_axis_tdata,   // grid_x, grid_y, zero pad
  output logic                          m_axis_tlast,   // run_last
  output logic [uglr_pkg::OutUserW-1:0] m_axis_tuser    // series_done, status
);

  import uglr_pkg::*;

  // run limit saturates at 64 samples
  localparam int unsigned RunLim = (MAX_RUN > 64) ? 64 : MAX_RUN;
  localparam int unsigned CntW = $clog2(RunLim + 2);
  localparam logic [CntW-1:0] MaxRunC = CntW'(RunLim);

  state_e state_q, state_d;

  logic [31:0]     step_q;
  logic [XW-1:0]   prev_x_q, prev_x_d;
  logic [YW-1:0]   prev_y_q, prev_y_d;
  logic [GXW-1:0]  next_grid_q, next_grid_d;
  logic            have_prev_q, have_prev_d;

  logic [XW-1:0]   x_q, x_d;
  logic [YW-1:0]   y_q, y_d;
  logic            last_q, last_d;
  logic [XW-1:0]   dx_q, dx_d;
  logic [YW-1:0]   a_q, a_d;
  logic            neg_q, neg_d;
  logic [GXW-1:0]  g_q, g_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            extra_q, extra_d;
  logic [31:0]     rem_q, rem_d;
  logic [31:0]     lo_q, lo_d;
  logic [4:0]      div_cnt_q, div_cnt_d;

  logic [GXW-1:0]  gx_q, gx_d;
  logic [YW-1:0]   gy_q, gy_d;
  logic            rl_q, rl_d;
  logic            sd_q, sd_d;
  status_e         st_q, st_d;

  logic [31:0]     step_eff;
  logic [GXW-1:0]  g_step;
  logic [GXW-1:0]  x_plus_step;
  logic [XW:0]     dx_in;
  logic [YW:0]     dy_in;
  logic [YW:0]     dy_abs;
  logic [XW-1:0]   off;
  logic [32:0]     div_t;
  logic            div_ge;
  logic [32:0]     div_sub;
  logic            extra_now;
  logic [CntW-1:0] total;
  logic            in_xfer;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {(OutDataW - GXW - YW)'(0), gy_q, gx_q};
  assign m_axis_tlast  = rl_q;
  assign m_axis_tuser  = {st_q, sd_q};

  // zero step behaves as a unit step
  assign step_eff    = (step_q == '0) ? 32'd1 : step_q;
  assign g_step      = g_q + {1'b0, step_eff};
  assign x_plus_step = {1'b0, x_q} + {1'b0, step_eff};

  assign dx_in  = {1'b0, s_axis_tdata[XW-1:0]} - {1'b0, prev_x_q};
  assign dy_in  = {s_axis_tdata[InDataW-1], s_axis_tdata[InDataW-1:XW]}
                - {prev_y_q[YW-1], prev_y_q};
  assign dy_abs = dy_in[YW] ? (~dy_in + (YW+1)'(1)) : dy_in;

  assign off = g_q[XW-1:0] - prev_x_q;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign div_t   = {rem_q, lo_q[31]};
  assign div_ge  = (div_t >= {1'b0, dx_q});
  assign div_sub = div_t - {1'b0, dx_q};

  assign extra_now = last_q && (g_q != x_plus_step);
  assign total     = cnt_q + CntW'(extra_now);

  always_comb begin
    state_d     = state_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    next_grid_d = next_grid_q;
    have_prev_d = have_prev_q;
    x_d         = x_q;
    y_d         = y_q;
    last_d      = last_q;
    dx_d        = dx_q;
    a_d         = a_q;
    neg_d       = neg_q;
    g_d         = g_q;
    cnt_d       = cnt_q;
    extra_d     = extra_q;
    rem_d       = rem_q;
    lo_d        = lo_q;
    div_cnt_d   = div_cnt_q;
    gx_d        = gx_q;
    gy_d        = gy_q;
    rl_d        = rl_q;
    sd_d        = sd_q;
    st_d        = st_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          x_d    = s_axis_tdata[XW-1:0];
          y_d    = s_axis_tdata[InDataW-1:XW];
          last_d = s_axis_tlast;
          dx_d   = dx_in[XW-1:0];
          a_d    = dy_abs[YW-1:0];
          neg_d  = dy_in[YW];
          g_d    = next_grid_q;
          cnt_d  = '0;
          if (!have_prev_q) begin
            if (s_axis_tlast) begin
              gx_d    = '0;
              gy_d    = '0;
              rl_d    = 1'b1;
              sd_d    = 1'b1;
              st_d    = STS_SHORT;
              state_d = ST_OUT;
            end else begin
              prev_x_d    = s_axis_tdata[XW-1:0];
              prev_y_d    = s_axis_tdata[InDataW-1:XW];
              next_grid_d = {1'b0, s_axis_tdata[XW-1:0]};
              have_prev_d = 1'b1;
            end
          end else if (dx_in[XW] || (dx_in[XW-1:0] == '0)) begin
            gx_d    = '0;
            gy_d    = '0;
            rl_d    = 1'b1;
            sd_d    = 1'b1;
            st_d    = STS_NOT_INCR;
            state_d = ST_OUT;
          end else begin
            state_d = ST_COUNT;
          end
        end
      end

      ST_COUNT: begin
        extra_d = extra_now;
        if ((g_q <= {1'b0, x_q}) && (cnt_q <= MaxRunC)) begin
          g_d   = g_step;
          cnt_d = cnt_q + CntW'(1);
        end else if ((cnt_q > MaxRunC) || (total > MaxRunC)) begin
          gx_d    = '0;
          gy_d    = '0;
          rl_d    = 1'b1;
          sd_d    = 1'b1;
          st_d    = STS_RUN_GAP;
          state_d = ST_OUT;
        end else begin
          // keep the end of the walk as the next grid position, rewind g
          next_grid_d = g_q;
          g_d         = next_grid_q;
          if (cnt_q != '0) begin
            state_d = ST_MUL;
          end else if (extra_now) begin
            gx_d    = g_q;
            gy_d    = y_q;
            rl_d    = 1'b1;
            sd_d    = 1'b1;
            st_d    = STS_OK;
            state_d = ST_OUT;
          end else begin
            if (last_q) begin
              prev_x_d    = '0;
              prev_y_d    = '0;
              next_grid_d = '0;
              have_prev_d = 1'b0;
            end else begin
              prev_x_d = x_q;
              prev_y_d = y_q;
            end
            state_d = ST_IDLE;
          end
        end
      end

      ST_MUL: begin
        {rem_d, lo_d} = a_q * off;
        div_cnt_d     = '0;
        state_d       = ST_DIV;
      end

      ST_DIV: begin
        rem_d     = div_ge ? div_sub[31:0] : div_t[31:0];
        lo_d      = {lo_q[30:0], div_ge};
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == '1) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        gx_d    = g_q;
        gy_d    = neg_q ? (prev_y_q - lo_q) : (prev_y_q + lo_q);
        rl_d    = (cnt_q == CntW'(1)) && !extra_q;
        sd_d    = (cnt_q == CntW'(1)) && !extra_q && last_q;
        st_d    = STS_OK;
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (m_axis_tready) begin
          if (rl_q) begin
            if (last_q || (st_q != STS_OK)) begin
              prev_x_d    = '0;
              prev_y_d    = '0;
              next_grid_d = '0;
              have_prev_d = 1'b0;
            end else begin
              prev_x_d = x_q;
              prev_y_d = y_q;
            end
            state_d = ST_IDLE;
          end else begin
            g_d   = g_step;
            cnt_d = cnt_q - CntW'(1);
            if (cnt_q != CntW'(1)) begin
              state_d = ST_MUL;
            end else begin
              // sample past the last x carries the last y
              gx_d = g_step;
              gy_d = y_q;
              rl_d = 1'b1;
              sd_d = 1'b1;
              st_d = STS_OK;
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 32'd1;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      next_grid_q <= '0;
      have_prev_q <= 1'b0;
      cnt_q       <= '0;
      extra_q     <= 1'b0;
      div_cnt_q   <= '0;
      rl_q        <= 1'b0;
      sd_q        <= 1'b0;
      st_q        <= STS_OK;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        step_q <= cfg_data_i;
      end
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      next_grid_q <= next_grid_d;
      have_prev_q <= have_prev_d;
      cnt_q       <= cnt_d;
      extra_q     <= extra_d;
      div_cnt_q   <= div_cnt_d;
      rl_q        <= rl_d;
      sd_q        <= sd_d;
      st_q        <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    last_q <= last_d;
    dx_q   <= dx_d;
    a_q    <= a_d;
    neg_q  <= neg_d;
    g_q    <= g_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    gx_q   <= gx_d;
    gy_q   <= gy_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (st_q != STS_OK)) |-> (rl_q && sd_q && (gx_q == '0)))
    else $error("error result not closing the series");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && sd_q) |-> rl_q)
    else $error("series end without run end");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> ((cnt_q != '0) && (cnt_q <= MaxRunC)))
    else $error("sample emission with bad remaining count");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> ($past(state_q) == ST_DIV))
    else $error("format step not preceded by divide");

endmodule
